// ===== src/bsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsdm_pkg
// Shared types and constants for the box scene distance block.
// ----------------------------------------------------------------------------
package bsdm_pkg;

   localparam int MAX_BOXES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORDS_PER_BOX = 13;
   localparam int SCALE_WORD    = 12;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic signed [31:0] DIST_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic               command;
      logic [5:0]         entry_index;
      logic [3:0]         word_index;
      logic signed [31:0] word_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] nearest_distance;
      logic               any_box;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef logic [WORDS_PER_BOX-1:0][31:0] box_words_type;
   typedef logic [2:0][31:0]               point_type;

endpackage

// ===== src/bsdm_eval.sv =====
// ----------------------------------------------------------------------------
// bsdm_eval
// Pipelined per-box evaluator: local transform, box distance, square root,
// scaling. Takes one box per cycle.
// ----------------------------------------------------------------------------
module bsdm_eval
   import bsdm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tag_type            in_tag,
   input  box_words_type      in_words,
   input  point_type          in_point,
   output tag_type            out_tag,
   output logic signed [31:0] out_dist
);

   localparam int SQ_STAGES = 16;
   localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      if (v > 67'sd2147483647) begin
         return DIST_MAX;
      end
      if (v < -67'sd2147483648) begin
         return {1'b1, 31'd0};
      end
      return v[31:0];
   endfunction

   // stage 1: products
   tag_type            t1_ff;
   logic signed [63:0] p1_ff [3][3];
   logic signed [63:0] tr1_ff [3];
   logic signed [31:0] sc1_ff;
   // stages 2..4: ordered saturating sums
   tag_type            t2_ff, t3_ff, t4_ff;
   logic signed [63:0] a2_ff [3], a3_ff [3], a4_ff [3];
   logic signed [63:0] p2b_ff [3], p2c_ff [3], p3c_ff [3];
   logic signed [31:0] sc2_ff, sc3_ff, sc4_ff;
   // stage 5: per-axis excess
   tag_type            t5_ff;
   logic signed [33:0] q5_ff [3];
   logic signed [31:0] sc5_ff;
   // stage 6: squares and inner term
   tag_type            t6_ff;
   logic [63:0]        sq6_ff [3];
   logic signed [33:0] in6_ff;
   logic signed [31:0] sc6_ff;
   // square root pipe, index 0 loaded from the sum of squares
   tag_type            tq_ff  [SQ_STAGES+1];
   logic [63:0]        nq_ff  [SQ_STAGES+1];
   logic [33:0]        rq_ff  [SQ_STAGES+1];
   logic [31:0]        oq_ff  [SQ_STAGES+1];
   logic signed [33:0] iq_ff  [SQ_STAGES+1];
   logic signed [31:0] sq_ff  [SQ_STAGES+1];
   // scale
   tag_type            t8_ff, t9_ff;
   logic signed [66:0] pd8_ff;
   logic signed [31:0] d9_ff;

   logic signed [34:0] d_in;
   logic signed [33:0] q_in [3];
   logic signed [33:0] inner_in;
   logic [31:0]        qpos_in [3];

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p1_ff[r][c] <= 64'($signed(in_words[r*4+c])) * 64'($signed(in_point[c]));
         end
         tr1_ff[r] <= 64'($signed(in_words[r*4+3])) <<< FRAC_BITS;
      end
      sc1_ff <= in_words[SCALE_WORD];

      for (int r = 0; r < 3; r++) begin
         a2_ff[r]  <= sat_add64(tr1_ff[r], p1_ff[r][0]);
         p2b_ff[r] <= p1_ff[r][1];
         p2c_ff[r] <= p1_ff[r][2];
         a3_ff[r]  <= sat_add64(a2_ff[r], p2b_ff[r]);
         p3c_ff[r] <= p2c_ff[r];
         a4_ff[r]  <= sat_add64(a3_ff[r], p3c_ff[r]);
         q5_ff[r]  <= q_in[r];
         sq6_ff[r] <= 64'(qpos_in[r]) * 64'(qpos_in[r]);
      end
      sc2_ff <= sc1_ff;
      sc3_ff <= sc2_ff;
      sc4_ff <= sc3_ff;
      sc5_ff <= sc4_ff;
      sc6_ff <= sc5_ff;
      in6_ff <= inner_in;

      nq_ff[0] <= sq6_ff[0] + sq6_ff[1] + sq6_ff[2];
      rq_ff[0] <= '0;
      oq_ff[0] <= '0;
      iq_ff[0] <= in6_ff;
      sq_ff[0] <= sc6_ff;

      pd8_ff <= 67'(d_in) * 67'(sq_ff[SQ_STAGES]);
      d9_ff  <= sat32(pd8_ff >>> FRAC_BITS);
   end

   always_comb begin
      logic signed [32:0] mag;
      logic signed [31:0] loc;
      logic signed [33:0] mx;
      for (int r = 0; r < 3; r++) begin
         loc     = sat32(67'(a4_ff[r] >>> FRAC_BITS));
         mag     = loc[31] ? -33'(loc) : 33'(loc);
         q_in[r] = 34'(mag) - HALF;
      end
      mx = q5_ff[0];
      if (q5_ff[1] > mx) begin
         mx = q5_ff[1];
      end
      if (q5_ff[2] > mx) begin
         mx = q5_ff[2];
      end
      inner_in = (mx > 34'sd0) ? 34'sd0 : mx;
      for (int r = 0; r < 3; r++) begin
         qpos_in[r] = (q5_ff[r] > 34'sd0) ? q5_ff[r][31:0] : 32'd0;
      end
      d_in = $signed({3'b000, oq_ff[SQ_STAGES]}) + 35'(iq_ff[SQ_STAGES]);
   end

   // two root digits per stage
   for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
      logic [63:0] n_nx;
      logic [33:0] r_nx;
      logic [31:0] o_nx;
      always_comb begin
         logic [35:0] rs;
         logic [35:0] trial;
         n_nx = nq_ff[i];
         r_nx = rq_ff[i];
         o_nx = oq_ff[i];
         for (int k = 0; k < 2; k++) begin
            rs    = {r_nx, n_nx[63:62]};
            n_nx  = {n_nx[61:0], 2'b00};
            trial = {2'b00, o_nx, 2'b01};
            if (rs >= trial) begin
               r_nx = 34'(rs - trial);
               o_nx = {o_nx[30:0], 1'b1};
            end else begin
               r_nx = rs[33:0];
               o_nx = {o_nx[30:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         nq_ff[i+1] <= n_nx;
         rq_ff[i+1] <= r_nx;
         oq_ff[i+1] <= o_nx;
         iq_ff[i+1] <= iq_ff[i];
         sq_ff[i+1] <= sq_ff[i];
         if (reset) begin
            tq_ff[i+1] <= '0;
         end else begin
            tq_ff[i+1] <= tq_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff    <= '0;
         t2_ff    <= '0;
         t3_ff    <= '0;
         t4_ff    <= '0;
         t5_ff    <= '0;
         t6_ff    <= '0;
         tq_ff[0] <= '0;
         t8_ff    <= '0;
         t9_ff    <= '0;
      end else begin
         t1_ff    <= in_tag;
         t2_ff    <= t1_ff;
         t3_ff    <= t2_ff;
         t4_ff    <= t3_ff;
         t5_ff    <= t4_ff;
         t6_ff    <= t5_ff;
         tq_ff[0] <= t6_ff;
         t8_ff    <= tq_ff[SQ_STAGES];
         t9_ff    <= t8_ff;
      end
   end

   assign out_tag  = t9_ff;
   assign out_dist = d9_ff;

endmodule

// ===== src/box_scene_distance_min_top.sv =====
// ----------------------------------------------------------------------------
// box_scene_distance_min_top
// Box table and minimum signed distance over the loaded boxes.
// ----------------------------------------------------------------------------
// A load beat writes one table word. A query beat walks the first count_cfg
// boxes (capped at MAX_BOXES) at one box per cycle through the evaluator
// pipeline, dominated by its 16-stage square root, and the block stalls
// requests until the result is moved to the output; a query with no boxes
// goes straight to the hold state. Table words need no clearing after reset.
module box_scene_distance_min_top
   import bsdm_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [6:0]         count_cfg_ff;
   logic [CW-1:0]      count_ff, count_in, count_sel;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               issuing_ff, issuing_in;
   logic signed [31:0] min_ff, min_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   point_type          point_ff, point_in;
   tag_type            rd_tag_ff;
   box_words_type      rd_ff;
   tag_type            ev_tag;
   logic signed [31:0] ev_dist;
   logic signed [31:0] min_nx;
   logic               accept, wr_en;
   logic [31:0]        cnt32, idx32;
   logic [AW-1:0]      wr_addr, rd_addr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign idx32   = 32'(req_data.entry_index);
   assign wr_addr = idx32[AW-1:0];
   assign wr_en   = accept && (req_data.command == CMD_LOAD) &&
                    (idx32 < 32'(MAX_BOXES)) &&
                    (32'(req_data.word_index) < 32'(WORDS_PER_BOX));
   assign rd_addr = issue_ff[AW-1:0];

   assign cnt32     = (32'(count_cfg_ff) > 32'(MAX_BOXES)) ? 32'(MAX_BOXES)
                                                          : 32'(count_cfg_ff);
   assign count_sel = cnt32[CW-1:0];

   for (genvar w = 0; w < WORDS_PER_BOX; w++) begin : g_mem
      logic [31:0] mem [MAX_BOXES];
      always_ff @(posedge clock) begin
         if (wr_en && (32'(req_data.word_index) == 32'(w))) begin
            mem[wr_addr] <= req_data.word_value;
         end
         rd_ff[w] <= mem[rd_addr];
      end
   end

   bsdm_eval #(
      .FRAC_BITS(FRAC_BITS)
   ) u_eval (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (rd_tag_ff),
      .in_words(rd_ff),
      .in_point(point_ff),
      .out_tag (ev_tag),
      .out_dist(ev_dist)
   );

   assign min_nx = (ev_dist < min_ff) ? ev_dist : min_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      issuing_in   = issuing_ff;
      min_in       = min_ff;
      res_in       = res_ff;
      point_in     = point_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.command == CMD_QUERY)) begin
               point_in = {req_data.point_z, req_data.point_y, req_data.point_x};
               count_in = count_sel;
               issue_in = '0;
               min_in   = DIST_MAX;
               if (count_sel == '0) begin
                  res_in   = '{nearest_distance: DIST_MAX, any_box: 1'b0};
                  state_in = ST_HOLD;
               end else begin
                  issuing_in = 1'b1;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (issuing_ff) begin
               issue_in = issue_ff + 1'b1;
               if (issue_ff == count_ff - 1'b1) begin
                  issuing_in = 1'b0;
               end
            end
            if (ev_tag.valid) begin
               min_in = min_nx;
               if (ev_tag.last) begin
                  res_in   = '{nearest_distance: min_nx, any_box: 1'b1};
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_cfg_ff <= '0;
         issuing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            count_cfg_ff <= csr_wdata;
         end
         issuing_ff   <= issuing_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_tag_ff    <= '{valid: issuing_ff,
                           last:  issuing_ff && (issue_ff == count_ff - 1'b1)};
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      issue_ff <= issue_in;
      min_ff   <= min_in;
      res_ff   <= res_in;
      point_ff <= point_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      issuing_ff |-> (state_ff == ST_RUN))
      else $error("box issue outside a query");
   a_eval_in_run: assert property (@(posedge clock) disable iff (reset)
      ev_tag.valid |-> (state_ff == ST_RUN))
      else $error("evaluator result outside a query");
   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_QUERY && count_sel == '0)
      |=> (state_ff == ST_HOLD && !res_ff.any_box))
      else $error("empty query not answered directly");
   a_hold_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("held result not moved to output");
`endif

endmodule
